// ===== hw/rtl/mtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-timer unit package
// Widths, command codes, register offsets and control word bit positions
// shared by the channel interfaces and the timer unit.
// ----------------------------------------------------------------------------
package mtu_pkg;

  localparam int MAX_TIMERS = 4;
  localparam int CMD_W      = 2;
  localparam int WORD_W     = 5;
  localparam int DATA_W     = 32;
  localparam int CTL_W      = 8;
  localparam int PRE_W      = 8;
  localparam int HALF_W     = 16;

  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [CTL_W-1:0]      ctl_t;
  typedef logic [PRE_W-1:0]      pre_t;
  typedef logic [MAX_TIMERS-1:0] tmask_t;
  typedef logic [2:0]            slot_t;
  typedef logic [1:0]            sub_t;
  typedef logic [1:0]            prescale_t;

  // Commands
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;

  // Shared register offsets
  localparam word_t REG_MASK   = 5'd0;
  localparam word_t REG_RAW    = 5'd1;
  localparam word_t REG_MASKED = 5'd2;
  localparam word_t REG_CLEAR  = 5'd3;

  // Per-timer register offsets within a slot of four words
  localparam sub_t SUB_LOAD    = 2'd0;
  localparam sub_t SUB_VALUE   = 2'd1;
  localparam sub_t SUB_CONTROL = 2'd2;
  localparam sub_t SUB_BGLOAD  = 2'd3;

  // Control word bits
  localparam int CTL_ENABLE_BIT   = 7;
  localparam int CTL_PERIODIC_BIT = 6;
  localparam int CTL_PRESCALE_HI  = 3;
  localparam int CTL_PRESCALE_LO  = 2;
  localparam int CTL_WIDE_BIT     = 1;
  localparam int CTL_ONESHOT_BIT  = 0;

  // Prescaler codes and terminal counts
  localparam prescale_t PRE_DIV1  = 2'd0;
  localparam prescale_t PRE_DIV16 = 2'd1;
  localparam pre_t PRE_LIMIT1   = 8'd0;
  localparam pre_t PRE_LIMIT16  = 8'd15;
  localparam pre_t PRE_LIMIT256 = 8'd255;

  localparam data_t MASK_WIDE = 32'hFFFF_FFFF;
  localparam data_t MASK_HALF = 32'h0000_FFFF;

endpackage

// ===== hw/rtl/mtu_if.sv =====
// ----------------------------------------------------------------------------
// Multi-timer unit channels
// Valid/ready channels for requests into the unit and responses out of it.
// ----------------------------------------------------------------------------
interface mtu_req_if;
  import mtu_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t reg_word;
  data_t write_data;

  modport source (output valid, output cmd, output reg_word, output write_data,
                  input ready);
  modport sink   (input valid, input cmd, input reg_word, input write_data,
                  output ready);
endinterface

interface mtu_rsp_if;
  import mtu_pkg::*;

  logic   valid;
  logic   ready;
  data_t  read_data;
  tmask_t irq_lines;

  modport source (output valid, output read_data, output irq_lines, input ready);
  modport sink   (input valid, input read_data, input irq_lines, output ready);
endinterface

// ===== hw/rtl/multi_timer_unit_four_channel.sv =====
// ----------------------------------------------------------------------------
// Multi-timer unit, four channels
// Decrementing timers with prescalers and a shared interrupt mask/status block.
// ----------------------------------------------------------------------------
// Each request on req is a timer tick, a register read or a register write.
// Every request produces exactly one response on rsp, carrying the read data
// (zero for ticks, writes and unused offsets) and the interrupt lines as they
// stand after the request.
// A request accepted at one clock edge has its response valid after that edge.
// The timer state is updated at the accepting edge by a single pass of logic,
// so one request is taken every cycle while the receiver does not stall.
// The response register frees the request side: outside reset, req.ready is
// high whenever the response register is empty or is being taken in the same
// cycle. While the receiver stalls, one response is held and the next request
// waits.
// Reset clears the mask and status, the load values, control words and
// prescalers, and sets every count to all ones; no response is pending and no
// request is taken while reset is high.
// ----------------------------------------------------------------------------
module multi_timer_unit_four_channel #(
  parameter int NUM_TIMERS = 4
) (
  input logic      clk,
  input logic      rst,
  mtu_req_if.sink  req,
  mtu_rsp_if.source rsp
);
  import mtu_pkg::*;

  localparam tmask_t TIMER_BITS = tmask_t'((1 << NUM_TIMERS) - 1);

  tmask_t irq_mask, irq_mask_next;
  tmask_t raw_status, raw_status_next;
  data_t  reload_value   [NUM_TIMERS];
  data_t  reload_value_next [NUM_TIMERS];
  data_t  count_value    [NUM_TIMERS];
  data_t  count_value_next  [NUM_TIMERS];
  ctl_t   control_word   [NUM_TIMERS];
  ctl_t   control_word_next [NUM_TIMERS];
  pre_t   prescale_count [NUM_TIMERS];
  pre_t   prescale_count_next [NUM_TIMERS];

  logic   out_valid;
  data_t  out_read_data;
  tmask_t out_irq_lines;
  data_t  read_data_next;

  logic   accept, is_tick, is_read, is_write;
  slot_t  slot;
  sub_t   sub;

  // Per-timer decode and counting-width views.
  data_t  wmask     [NUM_TIMERS];
  data_t  cur_count [NUM_TIMERS];
  pre_t   pre_limit [NUM_TIMERS];
  logic   slot_hit  [NUM_TIMERS];

  assign accept   = req.valid && req.ready;
  assign is_tick  = accept && (req.cmd == CMD_TICK);
  assign is_read  = accept && (req.cmd == CMD_READ);
  assign is_write = accept && (req.cmd == CMD_WRITE);
  assign slot     = req.reg_word[WORD_W-1:2];
  assign sub      = req.reg_word[1:0];

  assign req.ready     = !rst && (!out_valid || rsp.ready);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_read_data;
  assign rsp.irq_lines = out_irq_lines;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_view
    assign wmask[g]     = control_word[g][CTL_WIDE_BIT] ? MASK_WIDE : MASK_HALF;
    assign cur_count[g] = count_value[g] & wmask[g];
    assign slot_hit[g]  = (slot == slot_t'(g + 1));
    assign pre_limit[g] =
        (control_word[g][CTL_PRESCALE_HI:CTL_PRESCALE_LO] == PRE_DIV1)  ? PRE_LIMIT1 :
        (control_word[g][CTL_PRESCALE_HI:CTL_PRESCALE_LO] == PRE_DIV16) ? PRE_LIMIT16 :
                                                                          PRE_LIMIT256;
  end

  always_comb begin
    irq_mask_next   = irq_mask;
    raw_status_next = raw_status;
    read_data_next  = '0;

    if (is_write && (req.reg_word == REG_MASK)) begin
      irq_mask_next = req.write_data[MAX_TIMERS-1:0] & TIMER_BITS;
    end
    if (is_write && (req.reg_word == REG_CLEAR)) begin
      raw_status_next = raw_status & ~req.write_data[MAX_TIMERS-1:0];
    end

    if (is_read) begin
      unique case (req.reg_word)
        REG_MASK:   read_data_next = data_t'(irq_mask);
        REG_RAW:    read_data_next = data_t'(raw_status);
        REG_MASKED: read_data_next = data_t'(raw_status & irq_mask);
        default:    read_data_next = '0;
      endcase
    end

    for (int t = 0; t < NUM_TIMERS; t++) begin
      reload_value_next[t]   = reload_value[t];
      count_value_next[t]    = count_value[t];
      control_word_next[t]   = control_word[t];
      prescale_count_next[t] = prescale_count[t];

      if (is_tick && control_word[t][CTL_ENABLE_BIT]) begin
        if (prescale_count[t] >= pre_limit[t]) begin
          prescale_count_next[t] = '0;
          // A decrement from one or from zero expires the timer.
          if (cur_count[t] <= data_t'(1)) begin
            raw_status_next[t] = 1'b1;
            if (control_word[t][CTL_ONESHOT_BIT]) begin
              count_value_next[t] = '0;
              control_word_next[t][CTL_ENABLE_BIT] = 1'b0;
            end else if (control_word[t][CTL_PERIODIC_BIT]) begin
              count_value_next[t] = reload_value[t] & wmask[t];
            end else begin
              count_value_next[t] = wmask[t];
            end
          end else begin
            count_value_next[t] = (cur_count[t] - data_t'(1)) & wmask[t];
          end
        end else begin
          prescale_count_next[t] = prescale_count[t] + pre_t'(1);
        end
      end

      if (is_write && slot_hit[t]) begin
        case (sub)
          SUB_LOAD: begin
            reload_value_next[t]   = req.write_data;
            count_value_next[t]    = req.write_data;
            prescale_count_next[t] = '0;
          end
          SUB_CONTROL: begin
            control_word_next[t]   = req.write_data[CTL_W-1:0];
            prescale_count_next[t] = '0;
          end
          SUB_BGLOAD: reload_value_next[t] = req.write_data;
          default: ;
        endcase
      end

      if (is_read && slot_hit[t]) begin
        case (sub)
          SUB_VALUE:   read_data_next = count_value[t];
          SUB_CONTROL: read_data_next = data_t'(control_word[t]);
          default:     read_data_next = reload_value[t];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_mask   <= '0;
      raw_status <= '0;
      out_valid  <= 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        reload_value[t]   <= '0;
        count_value[t]    <= MASK_WIDE;
        control_word[t]   <= '0;
        prescale_count[t] <= '0;
      end
    end else begin
      irq_mask   <= irq_mask_next;
      raw_status <= raw_status_next;
      out_valid  <= accept || (out_valid && !rsp.ready);
      for (int t = 0; t < NUM_TIMERS; t++) begin
        reload_value[t]   <= reload_value_next[t];
        count_value[t]    <= count_value_next[t];
        control_word[t]   <= control_word_next[t];
        prescale_count[t] <= prescale_count_next[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data <= read_data_next;
      out_irq_lines <= raw_status_next & irq_mask_next;
    end
  end

`ifndef SYNTHESIS
  // The response loaded for a request reflects the status after that request.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid && (rsp.irq_lines == (raw_status & irq_mask)))
    else $error("response interrupt lines differ from masked status");

  // Status and mask bits of absent timers never get set.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> ((raw_status | irq_mask) & ~TIMER_BITS) == '0)
    else $error("status or mask bit set for an absent timer");

  // A disabled timer does not count on a tick.
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chk
    assert property (@(posedge clk) disable iff (rst)
      (is_tick && !control_word[g][CTL_ENABLE_BIT])
        |=> $stable(count_value[g]) && $stable(prescale_count[g]))
      else $error("disabled timer changed on a tick");
  end
`endif

endmodule

// ===== bench/multi_timer_unit_four_channel_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-timer unit checker
// Watches the request and response channels of the timer unit. It keeps its
// own copy of the timer state, works out the response each accepted request
// must produce, and compares every accepted response with the oldest one
// outstanding.
// ----------------------------------------------------------------------------
module multi_timer_unit_four_channel_checker #(
  parameter int NUM_TIMERS = 4
) (
  input  logic        clk,
  input  logic        rst,
  mtu_req_if          req,
  mtu_rsp_if          rsp,
  output int unsigned owed,
  output int unsigned errors,
  output int unsigned expiries
);
  import mtu_pkg::*;

  localparam word_t  TIMER_BASE = REG_CLEAR + word_t'(1);
  localparam int     SLOT_WORDS = 4;
  localparam tmask_t PRESENT    = tmask_t'((1 << NUM_TIMERS) - 1);

  typedef struct packed {
    data_t  read_data;
    tmask_t irq_lines;
  } rsp_item_t;

  tmask_t    irq_mask;
  tmask_t    raw_status;
  data_t     reload_val [MAX_TIMERS];
  data_t     count_val  [MAX_TIMERS];
  ctl_t      ctl_reg    [MAX_TIMERS];
  pre_t      pre_cnt    [MAX_TIMERS];
  rsp_item_t rsp_due [$];

  function automatic void reset_timers();
    irq_mask   = '0;
    raw_status = '0;
    for (int t = 0; t < MAX_TIMERS; t++) begin
      reload_val[t] = '0;
      count_val[t]  = MASK_WIDE;
      ctl_reg[t]    = '0;
      pre_cnt[t]    = '0;
    end
  endfunction

  // A decrement from one or from zero expires the timer.
  function automatic void count_down(int t);
    data_t wmask;
    data_t cur;
    wmask = ctl_reg[t][CTL_WIDE_BIT] ? MASK_WIDE : MASK_HALF;
    cur   = count_val[t] & wmask;
    if (cur <= 1) begin
      raw_status[t] = 1'b1;
      expiries++;
      if (ctl_reg[t][CTL_ONESHOT_BIT]) begin
        count_val[t] = '0;
        ctl_reg[t][CTL_ENABLE_BIT] = 1'b0;
      end else if (ctl_reg[t][CTL_PERIODIC_BIT]) begin
        count_val[t] = reload_val[t] & wmask;
      end else begin
        count_val[t] = wmask;
      end
    end else begin
      count_val[t] = (cur - 1) & wmask;
    end
  endfunction

  function automatic void tick_timers();
    prescale_t code;
    pre_t      limit;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (ctl_reg[t][CTL_ENABLE_BIT]) begin
        code  = ctl_reg[t][CTL_PRESCALE_HI:CTL_PRESCALE_LO];
        limit = (code == PRE_DIV1)  ? PRE_LIMIT1 :
                (code == PRE_DIV16) ? PRE_LIMIT16 : PRE_LIMIT256;
        if (pre_cnt[t] >= limit) begin
          pre_cnt[t] = '0;
          count_down(t);
        end else begin
          pre_cnt[t] = pre_cnt[t] + 1'b1;
        end
      end
    end
  endfunction

  function automatic data_t read_reg(word_t w);
    int   t;
    sub_t sub;
    if (w == REG_MASK)   return data_t'(irq_mask);
    if (w == REG_RAW)    return data_t'(raw_status);
    if (w == REG_MASKED) return data_t'(raw_status & irq_mask);
    if (w < TIMER_BASE)  return '0;
    t   = int'(w - TIMER_BASE) / SLOT_WORDS;
    sub = sub_t'(w - TIMER_BASE);
    if (t >= NUM_TIMERS) return '0;
    case (sub)
      SUB_VALUE:   return count_val[t];
      SUB_CONTROL: return data_t'(ctl_reg[t]);
      default:     return reload_val[t];
    endcase
  endfunction

  function automatic void write_reg(word_t w, data_t d);
    int   t;
    sub_t sub;
    if (w == REG_MASK) begin
      irq_mask = tmask_t'(d) & PRESENT;
    end else if (w == REG_CLEAR) begin
      raw_status = raw_status & ~tmask_t'(d);
    end else if (w >= TIMER_BASE) begin
      t   = int'(w - TIMER_BASE) / SLOT_WORDS;
      sub = sub_t'(w - TIMER_BASE);
      if (t < NUM_TIMERS) begin
        case (sub)
          SUB_LOAD: begin
            reload_val[t] = d;
            count_val[t]  = d;
            pre_cnt[t]    = '0;
          end
          SUB_CONTROL: begin
            ctl_reg[t] = d[CTL_W-1:0];
            pre_cnt[t] = '0;
          end
          SUB_BGLOAD: reload_val[t] = d;
          default: ;
        endcase
      end
    end
  endfunction

  function automatic rsp_item_t apply_request(cmd_t c, word_t w, data_t d);
    rsp_item_t r;
    r.read_data = '0;
    case (c)
      CMD_TICK:  tick_timers();
      CMD_READ:  r.read_data = read_reg(w);
      CMD_WRITE: write_reg(w, d);
      default: ;
    endcase
    r.irq_lines = raw_status & irq_mask;
    return r;
  endfunction

  // Responses are checked before the request of the same edge is applied;
  // as responses are registered, a response never belongs to that request.
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      reset_timers();
      rsp_due.delete();
      owed <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_due.size() == 0) begin
          $error("response accepted with no request outstanding");
          errors++;
        end else begin
          want = rsp_due.pop_front();
          if (rsp.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
            errors++;
          end
          if (rsp.irq_lines !== want.irq_lines) begin
            $error("irq_lines: expected %h, got %h", want.irq_lines, rsp.irq_lines);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        rsp_due.push_back(apply_request(req.cmd, req.reg_word, req.write_data));
      owed <= rsp_due.size();
    end
  end

endmodule

// ===== bench/multi_timer_unit_four_channel_tb.sv =====
// ----------------------------------------------------------------------------
// Multi-timer unit testbench
// Drives ticks, register reads and register writes into the timer unit with
// random gaps and random response stalls. A short directed part covers reset
// values, unused offsets, the unknown command and each expiry mode; the rest
// programs timers with small counts and runs them to expiry between bursts of
// random requests. The checker beside the unit compares every response.
// ----------------------------------------------------------------------------
module multi_timer_unit_four_channel_tb;
  import mtu_pkg::*;

  localparam int    NUM_TIMERS  = 4;
  localparam int    ITEM_TARGET = 2000;
  localparam int    QUIET_LIMIT = 2000;
  localparam int    SLOT_WORDS  = 4;
  localparam int    TICK_CAP    = 600;
  localparam word_t TIMER_BASE  = REG_CLEAR + word_t'(1);
  localparam word_t TOP_WORD    = '1;
  localparam cmd_t  CMD_UNKNOWN = 2'd3;

  localparam ctl_t CTL_EN   = ctl_t'(1) << CTL_ENABLE_BIT;
  localparam ctl_t CTL_PER  = ctl_t'(1) << CTL_PERIODIC_BIT;
  localparam ctl_t CTL_ONE  = ctl_t'(1) << CTL_ONESHOT_BIT;
  localparam ctl_t CTL_WIDE = ctl_t'(1) << CTL_WIDE_BIT;
  localparam ctl_t CTL_PRE_FIELD = ctl_t'(3) << CTL_PRESCALE_LO;

  logic clk;
  logic rst;

  mtu_req_if req_ch ();
  mtu_rsp_if rsp_ch ();

  int unsigned owed;
  int unsigned errors;
  int unsigned expiries;
  int unsigned sent, ticks, reads, writes;
  int unsigned quiet;
  int unsigned stall_left;
  bit          calm;

  multi_timer_unit_four_channel #(.NUM_TIMERS(NUM_TIMERS)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  multi_timer_unit_four_channel_checker #(.NUM_TIMERS(NUM_TIMERS)) u_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .owed     (owed),
    .errors   (errors),
    .expiries (expiries)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none at all while calm is set.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t timer_word(int t, sub_t s);
    return TIMER_BASE + word_t'(SLOT_WORDS * t) + word_t'(s);
  endfunction

  // Valid stays high after acceptance so that back-to-back requests never
  // drop it; callers that stop sending lower it through drain.
  task automatic send(cmd_t c, word_t w, data_t d);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.reg_word   <= w;
    req_ch.write_data <= d;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    case (c)
      CMD_TICK:  ticks++;
      CMD_READ:  reads++;
      CMD_WRITE: writes++;
      default: ;
    endcase
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  // Programs one timer with a small count and ticks it through a few
  // expiries, with reads, control rewrites and status clears mixed in.
  task automatic timer_scenario(bit slow);
    int        t;
    int        pick;
    int        div;
    int        cycles;
    prescale_t code;
    ctl_t      ctl;
    data_t     start;
    word_t     peek;
    t    = $urandom_range(NUM_TIMERS - 1);
    pick = $urandom_range(99);
    if (slow)           code = prescale_t'($urandom_range(2, 3));
    else if (pick < 80) code = PRE_DIV1;
    else if (pick < 97) code = PRE_DIV16;
    else                code = prescale_t'($urandom_range(2, 3));
    div = (code == PRE_DIV1) ? 1 : (code == PRE_DIV16) ? 16 : 256;
    ctl = (ctl_t'($urandom) & ~CTL_PRE_FIELD) | CTL_EN |
          (ctl_t'(code) << CTL_PRESCALE_LO);
    start = (div == 1) ? data_t'($urandom_range(0, 6)) : data_t'($urandom_range(0, 2));
    if (!ctl[CTL_WIDE_BIT] && $urandom_range(1) == 1)
      start[31:16] = 16'($urandom);
    if ($urandom_range(19) == 0)
      start = $urandom;

    if ($urandom_range(1) == 1) send(CMD_WRITE, REG_MASK, $urandom);
    send(CMD_WRITE, timer_word(t, SUB_LOAD), start);
    if ($urandom_range(1) == 1)
      send(CMD_WRITE, timer_word(t, SUB_BGLOAD),
           ($urandom_range(3) == 0) ? $urandom : data_t'($urandom_range(0, 5)));
    send(CMD_WRITE, timer_word(t, SUB_CONTROL), ($urandom & 32'hFFFF_FF00) | data_t'(ctl));

    cycles = div * (int'(start[2:0]) + 2) * $urandom_range(1, 3) + $urandom_range(0, 3);
    if (cycles > TICK_CAP) cycles = TICK_CAP;
    for (int i = 0; i < cycles; i++) begin
      send(CMD_TICK, word_t'($urandom), $urandom);
      pick = $urandom_range(99);
      if (pick < 12) begin
        case ($urandom_range(3))
          0:       peek = REG_RAW;
          1:       peek = REG_MASKED;
          2:       peek = timer_word(t, SUB_VALUE);
          default: peek = timer_word(t, SUB_CONTROL);
        endcase
        send(CMD_READ, peek, $urandom);
      end else if (pick < 14) begin
        send(CMD_WRITE, timer_word(t, SUB_CONTROL), data_t'(ctl));
      end else if (pick < 16) begin
        send(CMD_WRITE, REG_CLEAR, $urandom);
      end
    end

    send(CMD_READ, timer_word(t, SUB_VALUE), $urandom);
    send(CMD_READ, REG_MASKED, $urandom);
    send(CMD_WRITE, REG_CLEAR, ($urandom_range(1) == 1) ? MASK_WIDE : $urandom);
    if ($urandom_range(1) == 1) send(CMD_WRITE, timer_word(t, SUB_CONTROL), '0);
  endtask

  // Response side: ready with random stalls.
  initial begin
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    calm = 1'b0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_TICK;
    req_ch.reg_word   <= REG_MASK;
    req_ch.write_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values, unused offsets and the unknown command.
    send(CMD_READ, REG_RAW, '0);
    send(CMD_READ, timer_word(0, SUB_VALUE), '0);
    send(CMD_READ, TOP_WORD, MASK_WIDE);
    send(CMD_UNKNOWN, REG_MASK, MASK_WIDE);
    send(CMD_WRITE, REG_MASK, MASK_WIDE);
    send(CMD_READ, REG_MASK, '0);
    // One-shot from a count of one: stops at zero and clears its enable.
    send(CMD_WRITE, timer_word(0, SUB_LOAD), 32'd1);
    send(CMD_WRITE, timer_word(0, SUB_CONTROL), data_t'(CTL_EN | CTL_ONE | CTL_WIDE));
    send(CMD_TICK, '0, '0);
    send(CMD_READ, timer_word(0, SUB_CONTROL), '0);
    // Periodic from zero, reloading a background value cut to 16 bits.
    send(CMD_WRITE, timer_word(1, SUB_LOAD), '0);
    send(CMD_WRITE, timer_word(1, SUB_BGLOAD), 32'hFFFF_0003);
    send(CMD_WRITE, timer_word(1, SUB_CONTROL), data_t'(CTL_EN | CTL_PER));
    send(CMD_TICK, '0, '0);
    send(CMD_READ, timer_word(1, SUB_VALUE), '0);
    // Free-running 16-bit count with upper bits set: they clear on decrement.
    send(CMD_WRITE, timer_word(2, SUB_LOAD), 32'h0001_0002);
    send(CMD_WRITE, timer_word(2, SUB_CONTROL), data_t'(CTL_EN));
    send(CMD_TICK, TOP_WORD, MASK_WIDE);
    send(CMD_TICK, '0, '0);
    send(CMD_READ, timer_word(2, SUB_VALUE), '0);
    // One-shot and periodic together: one-shot wins.
    send(CMD_WRITE, timer_word(3, SUB_LOAD), 32'd1);
    send(CMD_WRITE, timer_word(3, SUB_CONTROL), data_t'(CTL_EN | CTL_PER | CTL_ONE));
    send(CMD_TICK, '0, '0);
    send(CMD_READ, REG_MASKED, '0);
    send(CMD_WRITE, REG_RAW, MASK_WIDE);
    send(CMD_WRITE, REG_CLEAR, MASK_WIDE);
    send(CMD_WRITE, TIMER_BASE + word_t'(SLOT_WORDS * NUM_TIMERS), 32'h1234_5678);
    send(CMD_READ, REG_RAW, '0);
    drain();

    timer_scenario(1'b1);
    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(9) == 0);
      if ($urandom_range(99) < 75) begin
        timer_scenario(1'b0);
      end else begin
        repeat ($urandom_range(3, 12))
          send(cmd_t'($urandom), word_t'($urandom), $urandom);
      end
      if ($urandom_range(7) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (4) @(posedge clk);
    $display("sent %0d requests: %0d ticks, %0d reads, %0d writes, rest unknown commands",
             sent, ticks, reads, writes);
    $display("timers expired %0d times across one-shot, periodic and free-running runs",
             expiries);
    if (errors == 0 && owed == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mtu_pkg.sv
hw/rtl/mtu_if.sv
hw/rtl/multi_timer_unit_four_channel.sv
bench/multi_timer_unit_four_channel_checker.sv
bench/multi_timer_unit_four_channel_tb.sv
